// ===== hdl/sdm_pkg.sv =====
`default_nettype none

package sdm_pkg;

    // Sigmoid table geometry
    localparam int SIGMOID_TABLE_ENTRIES = 256;
    localparam int IDX_W                 = $clog2(SIGMOID_TABLE_ENTRIES);

    // Saturation bound of slope * offset, 8.0 in Q16.16
    localparam int X_LIMIT = 524288;
    localparam int X_FRAC  = 20;            // log2 of the full span 2 * X_LIMIT

    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam int          EXP_TERMS = 24;

    typedef logic signed [15:0] q8_8_t;
    typedef logic        [15:0] q1_15_t;
    typedef logic [IDX_W-1:0]   sig_idx_t;

    typedef logic [SIGMOID_TABLE_ENTRIES-1:0][15:0] sig_table_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RISE_CENTRE = 3'd0,
        REG_RISE_SLOPE  = 3'd1,
        REG_FALL_SLOPE  = 3'd2,
        REG_FALL_CENTRE = 3'd3,
        REG_PEAK_HEIGHT = 3'd4
    } reg_index_t;

    typedef struct packed {
        q8_8_t  rise_centre;
        q8_8_t  rise_slope;
        q8_8_t  fall_slope;
        q8_8_t  fall_centre;
        q1_15_t peak_height;
    } cfg_t;

    // Load enables of the five pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_ld_t;

    // Shift-subtract division, used only while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-a in Q30 for a in [0, 2^30], truncated Taylor series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
        logic [63:0] term;
        longint      sum;
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        for (int n = 1; n <= EXP_TERMS; n++)
        begin
            term = div_u64((term * a) >> 30, 64'(n));
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(Q30_ONE))
            sum = longint'(Q30_ONE);
        return 64'(sum);
    endfunction

    function automatic logic [15:0] sig_entry(input int i);
        longint      xi;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] q;
        xi = longint'(div_u64(64'd1048576 * 64'(i), 64'(SIGMOID_TABLE_ENTRIES - 1)))
             - longint'(X_LIMIT);
        t  = (xi < 0) ? 64'(-xi) : 64'(xi);
        p  = exp_neg_q30((t << 14) >> 3);
        for (int k = 0; k < 3; k++)
            p = (p * p + (64'd1 << 29)) >> 30;
        d = Q30_ONE + p;
        if (xi >= 0)
            q = div_u64((64'd1 << 45) + (d >> 1), d);
        else
            q = div_u64((p << 15) + (d >> 1), d);
        return q[15:0];
    endfunction

    function automatic sig_table_t build_sig_table();
        sig_table_t tbl;
        for (int i = 0; i < SIGMOID_TABLE_ENTRIES; i++)
            tbl[i] = sig_entry(i);
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

// ===== hdl/sdm_if.sv =====
`default_nettype none

interface sdm_sample_if;
    import sdm_pkg::*;

    logic  valid;
    logic  ready;
    q8_8_t sample;
    logic  sample_missing;

    modport source (output valid, output sample, output sample_missing, input ready);
    modport sink   (input valid, input sample, input sample_missing, output ready);
endinterface

interface sdm_result_if;
    import sdm_pkg::*;

    logic   valid;
    logic   ready;
    q1_15_t membership;
    logic   undefined;

    modport source (output valid, output membership, output undefined, input ready);
    modport sink   (input valid, input membership, input undefined, output ready);
endinterface

`default_nettype wire

// ===== hdl/sigmoid_difference_membership_unit.sv =====
`default_nettype none

// Fuzzy membership unit: membership = |sig(rise_slope*(x-rise_centre)) -
// sig(fall_slope*(x-fall_centre))| * peak_height, with x in signed Q8.8 and
// the result in Q1.15; each slope product is clamped to +-8.0 and mapped onto
// a constant 256-entry sigmoid ROM built at elaboration. A sample flagged as
// missing yields membership 0 with undefined set. The unit is a five-stage
// pipeline (offset, slope multiply, clamp and index, ROM read and difference,
// height multiply) that takes one transfer per clock unless the result is
// stalled and every stage is full. Each stage holds its data while the
// stage after it is full and stalled, so bubbles close up and a stalled
// result never blocks new samples while an earlier stage is empty. Write the
// registers (index 0 rise_centre, 1 rise_slope, 2 fall_slope, 3 fall_centre,
// 4 peak_height) only while the pipeline is empty; writes to other indexes
// are dropped.
module sigmoid_difference_membership_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    sdm_sample_if.sink        sample_ch,
    sdm_result_if.source      result_ch,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_wdata
);
    import sdm_pkg::*;

    cfg_t      cfg;
    stage_ld_t ld;

    // Valid bits per stage and the missing flag alongside the data
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    logic m1_reg, m2_reg, m3_reg;
    logic m1_next, m2_next, m3_next;

    sig_idx_t rise_idx;
    sig_idx_t fall_idx;

    sdm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // A stage loads when it is empty or its successor loads too
    always_comb
    begin
        ld.s5 = !v5_reg || result_ch.ready;
        ld.s4 = !v4_reg || ld.s5;
        ld.s3 = !v3_reg || ld.s4;
        ld.s2 = !v2_reg || ld.s3;
        ld.s1 = !v1_reg || ld.s2;
    end

    assign sample_ch.ready = ld.s1;

    // Advance valid bits; hold on stall
    always_comb
    begin
        v1_next = ld.s1 ? sample_ch.valid : v1_reg;
        v2_next = ld.s2 ? v1_reg : v2_reg;
        v3_next = ld.s3 ? v2_reg : v3_reg;
        v4_next = ld.s4 ? v3_reg : v4_reg;
        v5_next = ld.s5 ? v4_reg : v5_reg;
        m1_next = ld.s1 ? sample_ch.sample_missing : m1_reg;
        m2_next = ld.s2 ? m1_reg : m2_reg;
        m3_next = ld.s3 ? m2_reg : m3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= m1_next;
        m2_reg <= m2_next;
        m3_reg <= m3_next;
    end

    // Stages 1 to 3, one copy per sigmoid
    sdm_index_path u_rise (
        .clk    (clk),
        .ld     (ld),
        .sample (sample_ch.sample),
        .centre (cfg.rise_centre),
        .slope  (cfg.rise_slope),
        .idx    (rise_idx)
    );

    sdm_index_path u_fall (
        .clk    (clk),
        .ld     (ld),
        .sample (sample_ch.sample),
        .centre (cfg.fall_centre),
        .slope  (cfg.fall_slope),
        .idx    (fall_idx)
    );

    // Stages 4 and 5; stage 5 is the output register
    sdm_scale u_scale (
        .clk         (clk),
        .ld          (ld),
        .rise_idx    (rise_idx),
        .fall_idx    (fall_idx),
        .missing     (m3_reg),
        .peak_height (cfg.peak_height),
        .membership  (result_ch.membership),
        .undefined   (result_ch.undefined)
    );

    assign result_ch.valid = v5_reg;

endmodule

`default_nettype wire

// ===== hdl/sdm_cfg.sv =====
`default_nettype none

module sdm_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_wdata,
    output sdm_pkg::cfg_t      cfg
);
    import sdm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_RISE_CENTRE: cfg_next.rise_centre = cfg_wdata;
                REG_RISE_SLOPE:  cfg_next.rise_slope  = cfg_wdata;
                REG_FALL_SLOPE:  cfg_next.fall_slope  = cfg_wdata;
                REG_FALL_CENTRE: cfg_next.fall_centre = cfg_wdata;
                REG_PEAK_HEIGHT: cfg_next.peak_height = cfg_wdata;
                default:         cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_centre <= 16'sd0;
            cfg_reg.rise_slope  <= 16'sd256;
            cfg_reg.fall_slope  <= 16'sd256;
            cfg_reg.fall_centre <= 16'sd0;
            cfg_reg.peak_height <= 16'd32768;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/sdm_index_path.sv =====
`default_nettype none

// Offset, slope product, saturation and table index for one sigmoid.
module sdm_index_path (
    input  wire logic              clk,
    input  wire sdm_pkg::stage_ld_t ld,
    input  wire sdm_pkg::q8_8_t    sample,
    input  wire sdm_pkg::q8_8_t    centre,
    input  wire sdm_pkg::q8_8_t    slope,
    output sdm_pkg::sig_idx_t      idx
);
    import sdm_pkg::*;

    localparam int SCALE_W = X_FRAC + 1 + IDX_W;

    localparam logic signed [32:0] X_HI = 33'(X_LIMIT);
    localparam logic signed [32:0] X_LO = -33'(X_LIMIT);

    logic signed [16:0] off_reg;
    logic signed [16:0] off_next;
    logic signed [32:0] prod_reg;
    logic signed [32:0] prod_next;
    sig_idx_t           idx_reg;
    sig_idx_t           idx_next;

    logic signed [32:0]   x_sat;
    logic [X_FRAC:0]      x_biased;
    logic [SCALE_W-1:0]   scaled;

    // Stage 1: offset from the centre
    assign off_next = 17'(sample) - 17'(centre);

    // Stage 2: slope times offset, Q16.16
    assign prod_next = 33'(slope) * 33'(off_reg);

    // Stage 3: clamp to +-8.0, map onto the table with rounding
    always_comb
    begin
        if (prod_reg > X_HI)
            x_sat = X_HI;
        else if (prod_reg < X_LO)
            x_sat = X_LO;
        else
            x_sat = prod_reg;
        x_biased = (X_FRAC + 1)'(x_sat + X_HI);
        scaled   = SCALE_W'(x_biased) * SCALE_W'(SIGMOID_TABLE_ENTRIES - 1)
                   + (SCALE_W'(1) << (X_FRAC - 1));
        idx_next = scaled[X_FRAC +: IDX_W];
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
            off_reg <= off_next;
        if (ld.s2)
            prod_reg <= prod_next;
        if (ld.s3)
            idx_reg <= idx_next;
    end

    assign idx = idx_reg;

endmodule

`default_nettype wire

// ===== hdl/sdm_scale.sv =====
`default_nettype none

// Table lookup, absolute difference and height scaling.
module sdm_scale (
    input  wire logic             clk,
    input  wire sdm_pkg::stage_ld_t ld,
    input  wire sdm_pkg::sig_idx_t rise_idx,
    input  wire sdm_pkg::sig_idx_t fall_idx,
    input  wire logic             missing,
    input  wire sdm_pkg::q1_15_t  peak_height,
    output sdm_pkg::q1_15_t       membership,
    output logic                  undefined
);
    import sdm_pkg::*;

    logic [15:0] diff_reg;
    logic [15:0] diff_next;
    logic        miss_reg;
    q1_15_t      memb_reg;
    q1_15_t      memb_next;
    logic        undef_reg;
    logic        undef_next;

    logic [15:0] rise_val;
    logic [15:0] fall_val;
    logic [31:0] product;
    logic [16:0] rounded;

    // Stage 4: read both sigmoids, take |rise - fall|
    always_comb
    begin
        rise_val  = SIG_TABLE[rise_idx];
        fall_val  = SIG_TABLE[fall_idx];
        diff_next = (rise_val >= fall_val) ? (rise_val - fall_val) : (fall_val - rise_val);
    end

    // Stage 5: scale by height, round, clip to the field
    always_comb
    begin
        product = 32'(diff_reg) * 32'(peak_height) + (32'd1 << 14);
        rounded = product[31:15];
        if (miss_reg)
        begin
            memb_next  = '0;
            undef_next = 1'b1;
        end
        else
        begin
            memb_next  = rounded[16] ? 16'hFFFF : rounded[15:0];
            undef_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s4)
        begin
            diff_reg <= diff_next;
            miss_reg <= missing;
        end
        if (ld.s5)
        begin
            memb_reg  <= memb_next;
            undef_reg <= undef_next;
        end
    end

    assign membership = memb_reg;
    assign undefined  = undef_reg;

endmodule

`default_nettype wire
